// ===== hdl/lph_pkg.sv =====
// ----------------------------------------------------------------------------
// lph_pkg
// Types and codes shared by the hash table block and its channel interfaces.
// ----------------------------------------------------------------------------
package lph_pkg;

  localparam logic [31:0] HASH_SEED = 32'd5381;

  typedef enum logic [1:0] {
    CMD_SEARCH = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_SPARE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_ABSENT  = 2'd1,
    ST_PRESENT = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_INIT_CAP = 2'd0;
  localparam logic [1:0] REG_LOAD_Q8  = 2'd1;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  key_byte;
    logic        key_last;
    logic [31:0] value_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value_out;
    logic [10:0] entry_count;
    logic [10:0] capacity_now;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [10:0] data;
  } cfg_item_t;

endpackage

// ===== hdl/lph_stream_if.sv =====
// ----------------------------------------------------------------------------
// lph_stream_if
// Valid/ready channel carrying one payload of a chosen type.
// ----------------------------------------------------------------------------
interface lph_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/linear_probe_hash_table_top.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_table_top
// Each key byte without the last flag is taken in as one transfer. After the
// last byte, the hash is reduced modulo the capacity and slots are probed one
// by one; a delete then scans the following slots, reducing each hash and
// moving an entry back into the hole where it may. A doubling before an insert
// clears the new bank and rehashes every used old slot into it. One operation
// runs at a time. After reset and after a write of initial_capacity, a clearing pass over the capacity runs.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_top #(
  parameter int MAX_SLOTS   = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  lph_stream_if.sink   in_ch,
  lph_stream_if.source out_ch,
  lph_stream_if.sink   cfg_ch
);
  import lph_pkg::*;

  localparam int AW = $clog2(MAX_SLOTS);
  localparam int CW = AW + 1;
  localparam int EW = 1 + 32 + VALUE_WIDTH;
  localparam int PW = CW + 9;

  // The table memory holds two banks; a doubling rehashes from one into the
  // other and then swaps them. Each word is {used, hash, value}.
  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_GROWCHK, S_GCLR, S_GRD, S_GEVAL, S_GPRD, S_GPEVAL,
    S_MOD, S_PRD, S_PEVAL, S_DNEXT, S_DEVAL, S_DSHIFT, S_DCLRJ, S_DONE
  } state_t;

  state_t               state_r, ret_r;
  logic [31:0]          hash_r, key_r, dividend_r;
  logic [1:0]           cmd_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [8:0]           lf_r;
  logic [CW-1:0]        cap_r, count_r, mod_cap_r, n_r, gi_r, clr_r, rem_r;
  logic [AW-1:0]        idx_r, hole_r;
  logic                 bank_r;
  logic [4:0]           dcnt_r;
  logic [EW-1:0]        ent_r, rdata_r;
  logic                 out_valid_r;
  logic [1:0]           status_r;
  logic [VALUE_WIDTH-1:0] vout_r;

  // Result held on the output channel until its transfer.
  logic [1:0]           out_status_r;
  logic [31:0]          out_value_r;
  logic [10:0]          out_count_r, out_cap_r;

  logic [EW-1:0]        mem [2*MAX_SLOTS];
  logic                 we;
  logic [AW:0]          wa, ra;
  logic [EW-1:0]        wd;

  // Fields of the word read last cycle.
  logic                 r_used;
  logic [31:0]          r_hash;
  logic [VALUE_WIDTH-1:0] r_val;
  assign r_used = rdata_r[EW-1];
  assign r_hash = rdata_r[EW-2 -: 32];
  assign r_val  = rdata_r[VALUE_WIDTH-1:0];

  // djb2 step on the incoming byte.
  logic [31:0] hash_nxt;
  assign hash_nxt = (hash_r << 5) + hash_r + {24'd0, in_ch.payload.key_byte};

  logic [63:0] vin64;
  logic [VALUE_WIDTH-1:0] vin;
  assign vin64 = {32'd0, in_ch.payload.value_in};
  assign vin   = vin64[VALUE_WIDTH-1:0];

  // Configured capacity, limited to 1..MAX_SLOTS.
  logic [31:0] cfg_cap32;
  logic [CW-1:0] cfg_cap;
  assign cfg_cap32 = {21'd0, cfg_ch.payload.data};
  always_comb begin
    if (cfg_cap32 == 32'd0) begin
      cfg_cap = CW'(1);
    end else if (cfg_cap32 > 32'(MAX_SLOTS)) begin
      cfg_cap = CW'(MAX_SLOTS);
    end else begin
      cfg_cap = cfg_cap32[CW-1:0];
    end
  end

  // Shared modulo unit: one restoring step per cycle.
  logic [CW:0]   rem_sh, rem_sub;
  logic [CW-1:0] rem_step;
  assign rem_sh   = {rem_r, dividend_r[31]};
  assign rem_sub  = rem_sh - {1'b0, mod_cap_r};
  assign rem_step = (rem_sh >= {1'b0, mod_cap_r}) ? rem_sub[CW-1:0] : rem_sh[CW-1:0];

  // Next slot with wraparound at the current modulus.
  logic [CW-1:0] idx_p1;
  logic [AW-1:0] idx_next;
  assign idx_p1   = {1'b0, idx_r} + CW'(1);
  assign idx_next = (idx_p1 >= mod_cap_r) ? '0 : idx_p1[AW-1:0];

  logic [CW-1:0] n_p1;
  assign n_p1 = n_r + CW'(1);

  // Doubling test before an insert.
  logic [PW-1:0] need, allow;
  logic          grow_ok;
  assign need    = PW'(count_r + CW'(1)) << 8;
  assign allow   = PW'(lf_r) * PW'(cap_r);
  assign grow_ok = (need > allow) && (({1'b0, cap_r} << 1) <= (CW+1)'(MAX_SLOTS));

  // Cyclic distances for the backward shift; rem_r holds the home slot.
  logic [CW:0] d_home_raw, d_hole_raw, d_home, d_hole;
  assign d_home_raw = {2'b0, idx_r} + {1'b0, mod_cap_r} - {1'b0, rem_r};
  assign d_hole_raw = {2'b0, idx_r} + {1'b0, mod_cap_r} - {2'b0, hole_r};
  assign d_home = (d_home_raw >= {1'b0, mod_cap_r}) ? d_home_raw - {1'b0, mod_cap_r}
                                                     : d_home_raw;
  assign d_hole = (d_hole_raw >= {1'b0, mod_cap_r}) ? d_hole_raw - {1'b0, mod_cap_r}
                                                     : d_hole_raw;

  logic [CW-1:0] two_cap;
  assign two_cap = cap_r << 1;

  // Memory port steering.
  always_comb begin
    we = 1'b0;
    wa = {bank_r, idx_r};
    wd = '0;
    ra = {bank_r, idx_r};
    case (state_r)
      S_CLR: begin
        we = 1'b1;
        wa = {bank_r, clr_r[AW-1:0]};
      end
      S_GCLR: begin
        we = 1'b1;
        wa = {~bank_r, clr_r[AW-1:0]};
      end
      S_GRD: begin
        ra = {bank_r, gi_r[AW-1:0]};
      end
      S_GPRD: begin
        ra = {~bank_r, idx_r};
      end
      S_GPEVAL: begin
        we = !r_used;
        wa = {~bank_r, idx_r};
        wd = {1'b1, ent_r[EW-2:0]};
      end
      S_PEVAL: begin
        if (cmd_r == CMD_INSERT) begin
          we = !r_used || (r_hash == key_r);
          wd = {1'b1, key_r, val_r};
        end else if (cmd_r == CMD_DELETE) begin
          we = r_used && (r_hash == key_r);
        end
      end
      S_DSHIFT: begin
        we = (d_home >= d_hole);
        wa = {bank_r, hole_r};
        wd = ent_r;
      end
      S_DCLRJ: begin
        we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_r <= mem[ra];
  end

  // A configuration transfer takes priority over the input channel while idle.
  assign in_ch.ready  = (state_r == S_IDLE) && !cfg_ch.valid;
  assign cfg_ch.ready = (state_r == S_IDLE);

  logic [63:0] vout64;
  assign vout64 = 64'(vout_r);
  assign out_ch.valid                = out_valid_r;
  assign out_ch.payload.status       = out_status_r;
  assign out_ch.payload.value_out    = out_value_r;
  assign out_ch.payload.entry_count  = out_count_r;
  assign out_ch.payload.capacity_now = out_cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      ret_r       <= S_PRD;
      hash_r      <= HASH_SEED;
      lf_r        <= 9'd192;
      cap_r       <= CW'(16 > MAX_SLOTS ? MAX_SLOTS : 16);
      count_r     <= '0;
      clr_r       <= '0;
      bank_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLR: begin
          clr_r <= clr_r + CW'(1);
          if (clr_r + CW'(1) >= cap_r) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cfg_ch.valid) begin
            // A capacity write clears the table and restarts the clearing pass.
            if (cfg_ch.payload.index == REG_INIT_CAP) begin
              cap_r   <= cfg_cap;
              count_r <= '0;
              clr_r   <= '0;
              state_r <= S_CLR;
            end else if (cfg_ch.payload.index == REG_LOAD_Q8) begin
              lf_r <= cfg_ch.payload.data[8:0];
            end
          end else if (in_ch.valid) begin
            if (!in_ch.payload.key_last) begin
              hash_r <= hash_nxt;
            end else begin
              hash_r     <= HASH_SEED;
              key_r      <= hash_nxt;
              cmd_r      <= in_ch.payload.command;
              val_r      <= vin;
              vout_r     <= '0;
              if (in_ch.payload.command == CMD_INSERT) begin
                state_r <= S_GROWCHK;
              end else begin
                dividend_r <= hash_nxt;
                rem_r      <= '0;
                dcnt_r     <= '0;
                mod_cap_r  <= cap_r;
                ret_r      <= S_PRD;
                state_r    <= S_MOD;
              end
            end
          end
        end
        S_GROWCHK: begin
          if (grow_ok) begin
            clr_r   <= '0;
            state_r <= S_GCLR;
          end else begin
            dividend_r <= key_r;
            rem_r      <= '0;
            dcnt_r     <= '0;
            mod_cap_r  <= cap_r;
            ret_r      <= S_PRD;
            state_r    <= S_MOD;
          end
        end
        S_GCLR: begin
          clr_r <= clr_r + CW'(1);
          if (clr_r + CW'(1) >= two_cap) begin
            gi_r    <= '0;
            state_r <= S_GRD;
          end
        end
        S_GRD: begin
          if (gi_r == cap_r) begin
            bank_r     <= ~bank_r;
            cap_r      <= two_cap;
            dividend_r <= key_r;
            rem_r      <= '0;
            dcnt_r     <= '0;
            mod_cap_r  <= two_cap;
            ret_r      <= S_PRD;
            state_r    <= S_MOD;
          end else begin
            state_r <= S_GEVAL;
          end
        end
        S_GEVAL: begin
          if (!r_used) begin
            gi_r    <= gi_r + CW'(1);
            state_r <= S_GRD;
          end else begin
            ent_r      <= rdata_r;
            dividend_r <= r_hash;
            rem_r      <= '0;
            dcnt_r     <= '0;
            mod_cap_r  <= two_cap;
            ret_r      <= S_GPRD;
            state_r    <= S_MOD;
          end
        end
        S_GPRD: begin
          state_r <= S_GPEVAL;
        end
        S_GPEVAL: begin
          if (!r_used) begin
            gi_r    <= gi_r + CW'(1);
            state_r <= S_GRD;
          end else begin
            idx_r   <= idx_next;
            state_r <= S_GPRD;
          end
        end
        S_MOD: begin
          rem_r      <= rem_step;
          dividend_r <= dividend_r << 1;
          dcnt_r     <= dcnt_r + 5'd1;
          if (dcnt_r == 5'd31) begin
            // The delete shift keeps its scan slot; other users start probing.
            if (ret_r != S_DSHIFT) begin
              idx_r <= rem_step[AW-1:0];
              n_r   <= '0;
            end
            state_r <= ret_r;
          end
        end
        S_PRD: begin
          state_r <= S_PEVAL;
        end
        S_PEVAL: begin
          if (cmd_r == CMD_INSERT) begin
            if (r_used && r_hash == key_r) begin
              status_r <= ST_PRESENT;
              state_r  <= S_DONE;
            end else if (!r_used) begin
              count_r  <= count_r + CW'(1);
              status_r <= ST_DONE;
              state_r  <= S_DONE;
            end else if (n_p1 >= mod_cap_r) begin
              status_r <= ST_FULL;
              state_r  <= S_DONE;
            end else begin
              n_r     <= n_p1;
              idx_r   <= idx_next;
              state_r <= S_PRD;
            end
          end else begin
            if (!r_used) begin
              status_r <= ST_ABSENT;
              state_r  <= S_DONE;
            end else if (r_hash == key_r) begin
              if (cmd_r == CMD_DELETE) begin
                hole_r  <= idx_r;
                idx_r   <= idx_next;
                n_r     <= CW'(1);
                state_r <= S_DNEXT;
              end else begin
                vout_r   <= r_val;
                status_r <= ST_DONE;
                state_r  <= S_DONE;
              end
            end else if (n_p1 >= mod_cap_r) begin
              status_r <= ST_ABSENT;
              state_r  <= S_DONE;
            end else begin
              n_r     <= n_p1;
              idx_r   <= idx_next;
              state_r <= S_PRD;
            end
          end
        end
        S_DNEXT: begin
          if (n_r >= mod_cap_r) begin
            if (count_r != '0) begin
              count_r <= count_r - CW'(1);
            end
            status_r <= ST_DONE;
            state_r  <= S_DONE;
          end else begin
            state_r <= S_DEVAL;
          end
        end
        S_DEVAL: begin
          if (!r_used) begin
            if (count_r != '0) begin
              count_r <= count_r - CW'(1);
            end
            status_r <= ST_DONE;
            state_r  <= S_DONE;
          end else begin
            ent_r      <= rdata_r;
            dividend_r <= r_hash;
            rem_r      <= '0;
            dcnt_r     <= '0;
            ret_r      <= S_DSHIFT;
            state_r    <= S_MOD;
          end
        end
        S_DSHIFT: begin
          if (d_home >= d_hole) begin
            state_r <= S_DCLRJ;
          end else begin
            idx_r   <= idx_next;
            n_r     <= n_p1;
            state_r <= S_DNEXT;
          end
        end
        S_DCLRJ: begin
          hole_r  <= idx_r;
          idx_r   <= idx_next;
          n_r     <= n_p1;
          state_r <= S_DNEXT;
        end
        S_DONE: begin
          // The result is copied to the output register once it is free, so the
          // next operation can run while this one waits for its transfer.
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_r;
            out_value_r  <= vout64[31:0];
            out_count_r  <= 11'(count_r);
            out_cap_r    <= 11'(cap_r);
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // The stored key count never exceeds the slot count.
  a_count_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cap_r)
    else $error("entry count exceeds capacity");

  // Capacity changes only by doubling or by a configuration write.
  a_cap_change: assert property (@(posedge clk) disable iff (!rst_n)
    (cap_r != $past(cap_r)) |->
      ((cap_r == ($past(cap_r) << 1)) || $past(cfg_ch.valid) || $past(!rst_n)))
    else $error("capacity changed without doubling");

  // A probe always addresses a slot inside the table in use.
  a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PRD || state_r == S_GPRD) |-> ({1'b0, idx_r} < mod_cap_r))
    else $error("probe slot outside table");

  // The clearing pass always runs over at least one slot.
  a_init_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> (cap_r != '0))
    else $error("zero capacity during clear");

endmodule

// ===== tb/tb_linear_probe_hash_table_top.sv =====
// ----------------------------------------------------------------------------
// tb_linear_probe_hash_table_top
// Self-checking bench for the linear probing hash table. Key bytes are sent
// over the input channel. A behavioral table in the bench predicts the status,
// value, count and capacity of each operation. Results are compared in order.
// ----------------------------------------------------------------------------
module tb_linear_probe_hash_table_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lph_pkg::*;

  localparam int SLOTS = 1024;
  localparam int WATCHDOG = 400000;

  logic clk;
  logic rst_n;

  lph_stream_if #(.T(in_item_t))  in_ch ();
  lph_stream_if #(.T(out_item_t)) out_ch ();
  lph_stream_if #(.T(cfg_item_t)) cfg_ch ();

  linear_probe_hash_table_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg_ch(cfg_ch.sink)
  );

  // Predicted table state.
  logic [10:0] mdl_init_cap;
  logic [8:0]  mdl_load;
  logic [31:0] mdl_hash;
  bit          tbl_used [SLOTS];
  logic [31:0] tbl_key  [SLOTS];
  logic [31:0] tbl_val  [SLOTS];
  int unsigned tbl_count;
  int unsigned tbl_cap;

  out_item_t   pending_results[$];
  logic [31:0] known_keys[$];
  int          mismatches;
  bit          timed_out;
  bit          rx_stall_req;
  bit          rx_random_idle;
  bit          tx_random_idle;
  int          idle_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned clamp_cap(logic [10:0] v);
    if (v == 0) return 1;
    if (v > SLOTS) return SLOTS;
    return v;
  endfunction

  function automatic void table_clear();
    for (int i = 0; i < SLOTS; i++) tbl_used[i] = 0;
    tbl_count = 0;
    tbl_cap = clamp_cap(mdl_init_cap);
  endfunction

  function automatic void table_place(logic [31:0] h, logic [31:0] v);
    int unsigned idx;
    idx = h % tbl_cap;
    for (int n = 0; n < tbl_cap; n++) begin
      if (!tbl_used[idx]) begin
        tbl_used[idx] = 1; tbl_key[idx] = h; tbl_val[idx] = v;
        return;
      end
      idx = (idx + 1 >= tbl_cap) ? 0 : idx + 1;
    end
  endfunction

  function automatic void table_grow();
    bit          u [SLOTS];
    logic [31:0] k [SLOTS];
    logic [31:0] v [SLOTS];
    int unsigned old;
    old = tbl_cap;
    u = tbl_used; k = tbl_key; v = tbl_val;
    tbl_cap = old * 2;
    for (int i = 0; i < SLOTS; i++) tbl_used[i] = 0;
    for (int i = 0; i < old; i++) if (u[i]) table_place(k[i], v[i]);
  endfunction

  function automatic bit table_find(logic [31:0] h, output int unsigned where);
    int unsigned idx;
    idx = h % tbl_cap;
    where = 0;
    for (int n = 0; n < tbl_cap; n++) begin
      if (!tbl_used[idx]) return 0;
      if (tbl_key[idx] == h) begin
        where = idx;
        return 1;
      end
      idx = (idx + 1 >= tbl_cap) ? 0 : idx + 1;
    end
    return 0;
  endfunction

  function automatic status_t table_insert(logic [31:0] h, logic [31:0] v);
    longint unsigned need, allow;
    int unsigned idx;
    need = (longint'(tbl_count) + 1) * 256;
    allow = longint'(mdl_load) * tbl_cap;
    if (need > allow && tbl_cap * 2 <= SLOTS) table_grow();
    idx = h % tbl_cap;
    for (int n = 0; n < tbl_cap; n++) begin
      if (tbl_used[idx] && tbl_key[idx] == h) begin
        tbl_val[idx] = v;
        return ST_PRESENT;
      end
      if (!tbl_used[idx]) begin
        tbl_used[idx] = 1; tbl_key[idx] = h; tbl_val[idx] = v;
        tbl_count++;
        return ST_DONE;
      end
      idx = (idx + 1 >= tbl_cap) ? 0 : idx + 1;
    end
    return ST_FULL;
  endfunction

  function automatic status_t table_delete(logic [31:0] h);
    int unsigned hole, j, home, d_home, d_hole, cap;
    cap = tbl_cap;
    if (!table_find(h, hole)) return ST_ABSENT;
    tbl_used[hole] = 0;
    j = (hole + 1 >= cap) ? 0 : hole + 1;
    for (int n = 1; n < cap; n++) begin
      if (!tbl_used[j]) break;
      home = tbl_key[j] % cap;
      d_home = (j + cap - home) % cap;
      d_hole = (j + cap - hole) % cap;
      if (d_home >= d_hole) begin
        tbl_used[hole] = 1; tbl_key[hole] = tbl_key[j]; tbl_val[hole] = tbl_val[j];
        tbl_used[j] = 0;
        hole = j;
      end
      j = (j + 1 >= cap) ? 0 : j + 1;
    end
    if (tbl_count > 0) tbl_count--;
    return ST_DONE;
  endfunction

  // Advances the running hash by one byte and, on the last byte, runs the
  // operation and queues the expected result.
  function automatic void predict_operation(in_item_t it);
    logic [31:0] h;
    out_item_t r;
    int unsigned idx;
    h = (mdl_hash << 5) + mdl_hash + it.key_byte;
    if (!it.key_last) begin
      mdl_hash = h;
      return;
    end
    mdl_hash = HASH_SEED;
    r.value_out = '0;
    case (it.command)
      CMD_INSERT: r.status = table_insert(h, it.value_in);
      CMD_DELETE: r.status = table_delete(h);
      default: begin
        if (table_find(h, idx)) begin
          r.status = ST_DONE;
          r.value_out = tbl_val[idx];
        end else begin
          r.status = ST_ABSENT;
        end
      end
    endcase
    r.entry_count = tbl_count[10:0];
    r.capacity_now = tbl_cap[10:0];
    pending_results.push_back(r);
  endfunction

  task automatic wait_idle(int unsigned gap);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (gap) @(posedge clk);
  endtask

  // One transfer on the input channel, with an optional random gap first.
  // Valid stays high after the transfer until the next byte or a pause.
  task automatic send_byte(cmd_t cmd, logic [7:0] b, bit last, logic [31:0] v);
    in_item_t it;
    if (tx_random_idle && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    it.command = cmd; it.key_byte = b; it.key_last = last; it.value_in = v;
    in_ch.valid <= 1'b1;
    in_ch.payload <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_operation(it);
  endtask

  task automatic send_key(cmd_t cmd, logic [31:0] keyword, int len, logic [31:0] v);
    for (int i = 0; i < len; i++)
      send_byte(CMD_SPARE, keyword[8*(i%4) +: 8] ^ i[7:0], 1'b0, $urandom);
    send_byte(cmd, keyword[31:24], 1'b1, v);
    if (cmd == CMD_INSERT) known_keys.push_back(keyword);
  endtask

  // Register writes only happen with the table quiet. A capacity write also
  // clears the table, so the keys seen so far are forgotten.
  task automatic write_reg(logic [1:0] index, logic [10:0] data);
    cfg_item_t c;
    wait_idle(4000);
    c.index = index; c.data = data;
    cfg_ch.valid <= 1'b1;
    cfg_ch.payload <= c;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (index == REG_INIT_CAP) begin
      mdl_init_cap = data;
      table_clear();
      known_keys.delete();
    end else begin
      mdl_load = data[8:0];
    end
  endtask

  // Result checker: compare each transfer with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_ch.payload);
      end else begin
        out_item_t e;
        e = pending_results.pop_front();
        if (e !== out_ch.payload) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %p actual %p",
                                         e, out_ch.payload);
        end
      end
    end
  end

  // Receiver: random back pressure in bursts, or a long hold-off on request.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_stall_req) begin
        out_ch.ready <= 1'b0;
        repeat (600) @(posedge clk);
        rx_stall_req = 0;
      end else if (rx_random_idle && $urandom_range(0, 6) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: cycles with no transfer on any channel.
  always @(posedge clk) begin
    if (in_ch.valid && in_ch.ready || out_ch.valid && out_ch.ready ||
        cfg_ch.valid && cfg_ch.ready)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG && !timed_out) begin
      timed_out = 1;
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [31:0] pick_key();
    if (known_keys.size() != 0 && $urandom_range(0, 2) != 0)
      return known_keys[$urandom_range(0, known_keys.size() - 1)];
    return $urandom;
  endfunction

  // Single byte keys hash to 5381*33 + b, so a chosen key is easy to reuse.
  task automatic test_directed();
    send_byte(CMD_SEARCH, 8'h00, 1'b1, 32'h0);
    send_byte(CMD_INSERT, 8'h00, 1'b1, 32'hFFFF_FFFF);
    send_byte(CMD_INSERT, 8'hFF, 1'b1, 32'h0);
    send_byte(CMD_INSERT, 8'h00, 1'b1, 32'h1234_5678);
    send_byte(CMD_SEARCH, 8'h00, 1'b1, 32'h0);
    send_byte(CMD_SPARE, 8'hFF, 1'b1, 32'h0);
    send_byte(CMD_SPARE, 8'h00, 1'b0, 32'hFFFF_FFFF);
    send_byte(CMD_INSERT, 8'h00, 1'b1, 32'hA5A5_5A5A);
    send_byte(CMD_SPARE, 8'h00, 1'b0, 32'h0);
    send_byte(CMD_SEARCH, 8'h00, 1'b1, 32'h0);
    send_byte(CMD_DELETE, 8'h00, 1'b1, 32'h0);
    send_byte(CMD_DELETE, 8'h00, 1'b1, 32'h0);
    send_byte(CMD_SEARCH, 8'hFF, 1'b1, 32'h0);
    for (int i = 0; i < 8; i++) send_byte(CMD_INSERT, i[7:0] * 8'd16, 1'b1, $urandom);
    send_byte(CMD_DELETE, 8'h10, 1'b1, 32'h0);
    send_byte(CMD_SEARCH, 8'h70, 1'b1, 32'h0);
  endtask

  // Bursts of mixed operations on a mostly known key set. The key length
  // follows from the key word, so a reused word rebuilds the same key.
  task automatic test_random_ops(int n, int maxlen);
    int r;
    int len;
    logic [31:0] k;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      k = pick_key();
      len = int'(k[3:0]) % (maxlen + 1);
      if (r < 4)
        send_key(CMD_INSERT, k, len, $urandom);
      else if (r < 7)
        send_key(CMD_SEARCH, k, len, 32'h0);
      else if (r < 9)
        send_key(CMD_DELETE, k, len, 32'h0);
      else
        send_key(CMD_SPARE, k, 0, $urandom);
    end
  endtask

  // Tiny tables at the load limit reach both the full status and doubling
  // being refused at the largest size.
  task automatic test_capacity_extremes();
    write_reg(REG_INIT_CAP, 11'd1);
    write_reg(REG_LOAD_Q8, 11'd256);
    test_random_ops(20, 0);
    write_reg(REG_INIT_CAP, 11'd0);
    test_random_ops(10, 0);
    write_reg(REG_INIT_CAP, 11'd1024);
    test_random_ops(20, 1);
    write_reg(REG_INIT_CAP, 11'h7FF);
    test_random_ops(10, 0);
    write_reg(REG_INIT_CAP, 11'd3);
    write_reg(REG_LOAD_Q8, 11'd0);
    test_random_ops(20, 0);
    write_reg(REG_LOAD_Q8, 11'h1FF);
    write_reg(REG_INIT_CAP, 11'd5);
    test_random_ops(30, 0);
    write_reg(REG_LOAD_Q8, 11'd1);
    write_reg(REG_INIT_CAP, 11'd2);
    test_random_ops(25, 1);
  endtask

  // The receiver holds off while the sender keeps going, then the sender
  // waits for every result before continuing.
  task automatic test_back_pressure();
    write_reg(REG_LOAD_Q8, 11'd192);
    write_reg(REG_INIT_CAP, 11'd8);
    rx_stall_req = 1;
    test_random_ops(12, 1);
    wait_idle(0);
    test_random_ops(12, 1);
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.payload = '0;
    mismatches = 0;
    timed_out = 0;
    rx_stall_req = 0;
    rx_random_idle = 1;
    tx_random_idle = 1;
    mdl_init_cap = 11'd16;
    mdl_load = 9'd192;
    mdl_hash = HASH_SEED;
    table_clear();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_capacity_extremes();
    test_back_pressure();
    write_reg(REG_INIT_CAP, 11'd16);
    write_reg(REG_LOAD_Q8, 11'd192);
    test_random_ops(250, 2);
    write_reg(REG_INIT_CAP, 11'd4);
    test_random_ops(150, 1);
    rx_random_idle = 0;
    tx_random_idle = 0;
    test_random_ops(300, 1);

    wait_idle(4000);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
